@@ hw/rtl/sjds_pkg.sv @@
// sjds_pkg: shared types, constants and detent helper for the servo jog block
`default_nettype none

package sjds_pkg;

    // angle width and detent spacing
    localparam int unsigned ANGLE_W = 8;
    localparam logic [ANGLE_W-1:0] DETENT = 8'd45;
    localparam logic [ANGLE_W-1:0] ANGLE_SAT = 8'd255;
    localparam int unsigned DETENT_LEVELS = 5;

    typedef logic [ANGLE_W-1:0] angle_t;

    // one poll item
    typedef struct packed {
        logic   up_press;
        logic   down_press;
        logic   open_press;
        logic   close_press;
        angle_t rotate_now;
        angle_t grab_now;
    } poll_item_t;

    // one command item
    typedef struct packed {
        logic   rotate_cmd_valid;
        angle_t rotate_cmd;
        logic   grab_cmd_valid;
        angle_t grab_cmd;
    } cmd_item_t;

    // run flags and latched rotate targets
    typedef struct packed {
        logic   up_running;
        logic   down_running;
        logic   open_running;
        logic   close_running;
        angle_t up_target;
        angle_t down_target;
    } jog_state_t;

    // largest multiple of the detent spacing not above v
    function automatic angle_t detent_floor(input angle_t v);
        angle_t f;
        f = '0;
        for (int unsigned k = 1; k <= DETENT_LEVELS; k++) begin
            if (9'(v) >= 9'(k * 45))
            begin
                f = ANGLE_W'(k * 45);
            end
        end
        return f;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/sjds_poll_if.sv @@
// sjds_poll_if: valid/ready channel carrying one poll item
`default_nettype none

interface sjds_poll_if;
    import sjds_pkg::*;

    logic   valid;
    logic   ready;
    logic   up_press;
    logic   down_press;
    logic   open_press;
    logic   close_press;
    angle_t rotate_now;
    angle_t grab_now;

    modport source (
        output valid, up_press, down_press, open_press, close_press, rotate_now, grab_now,
        input  ready
    );

    modport sink (
        input  valid, up_press, down_press, open_press, close_press, rotate_now, grab_now,
        output ready
    );
endinterface

`default_nettype wire

@@ hw/rtl/sjds_cmd_if.sv @@
// sjds_cmd_if: valid/ready channel carrying one servo command item
`default_nettype none

interface sjds_cmd_if;
    import sjds_pkg::*;

    logic   valid;
    logic   ready;
    logic   rotate_cmd_valid;
    angle_t rotate_cmd;
    logic   grab_cmd_valid;
    angle_t grab_cmd;

    modport source (
        output valid, rotate_cmd_valid, rotate_cmd, grab_cmd_valid, grab_cmd,
        input  ready
    );

    modport sink (
        input  valid, rotate_cmd_valid, rotate_cmd, grab_cmd_valid, grab_cmd,
        output ready
    );
endinterface

`default_nettype wire

@@ hw/rtl/sjds_step.sv @@
// sjds_step: per-poll run toggling, detent stops and step command logic
`default_nettype none

module sjds_step
    import sjds_pkg::*;
#(
    parameter int unsigned MAX_ANGLE = 180
) (
    input  wire poll_item_t item,
    input  wire jog_state_t state,
    output jog_state_t      state_next,
    output cmd_item_t       result
);

    localparam angle_t MAX_A = ANGLE_W'(MAX_ANGLE);

    angle_t up_floor;
    angle_t rot_dec;
    angle_t up_start_target;
    angle_t down_start_target;

    // detent targets latched when a run starts
    always_comb
    begin
        up_floor = detent_floor(item.rotate_now);
        rot_dec = item.rotate_now - 8'd1;
        if (up_floor == ANGLE_W'(DETENT_LEVELS * 45))
        begin
            up_start_target = ANGLE_SAT;
        end
        else
        begin
            up_start_target = up_floor + DETENT;
        end
        if (item.rotate_now == '0)
        begin
            down_start_target = '0;
        end
        else
        begin
            down_start_target = detent_floor(rot_dec);
        end
    end

    // run updates and step commands, down/close applied last so it wins
    always_comb
    begin
        state_next = state;
        result = '0;

        // rotate up
        if (item.up_press)
        begin
            if (!state.up_running)
            begin
                state_next.up_running = 1'b1;
                state_next.up_target = up_start_target;
            end
            else
            begin
                state_next.up_running = 1'b0;
            end
        end
        else
        begin
            if (state.up_target > MAX_A)
            begin
                state_next.up_running = 1'b0;
            end
            if (state_next.up_running)
            begin
                if (item.rotate_now < state.up_target)
                begin
                    result.rotate_cmd_valid = 1'b1;
                    result.rotate_cmd = item.rotate_now + 8'd1;
                end
                else
                begin
                    state_next.up_running = 1'b0;
                end
            end
        end

        // rotate down
        if (item.down_press)
        begin
            if (!state.down_running)
            begin
                state_next.down_running = 1'b1;
                state_next.down_target = down_start_target;
            end
            else
            begin
                state_next.down_running = 1'b0;
            end
        end
        else if (state.down_running)
        begin
            if (item.rotate_now > state.down_target)
            begin
                result.rotate_cmd_valid = 1'b1;
                result.rotate_cmd = rot_dec;
            end
            else
            begin
                state_next.down_running = 1'b0;
            end
        end

        // grab open
        if (item.open_press)
        begin
            state_next.open_running = !state.open_running;
        end
        else
        begin
            if (item.grab_now >= MAX_A)
            begin
                state_next.open_running = 1'b0;
            end
            if (state_next.open_running)
            begin
                result.grab_cmd_valid = 1'b1;
                result.grab_cmd = item.grab_now + 8'd1;
            end
        end

        // grab close
        if (item.close_press)
        begin
            state_next.close_running = !state.close_running;
        end
        else
        begin
            if (item.grab_now == '0)
            begin
                state_next.close_running = 1'b0;
            end
            if (state_next.close_running)
            begin
                result.grab_cmd_valid = 1'b1;
                result.grab_cmd = item.grab_now - 8'd1;
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/servo_jog_with_detent_stops.sv @@
// servo_jog_with_detent_stops: top level of the rotate/grab servo jog controller
//
//  channel | dir | interface      | item
//  --------+-----+----------------+----------------------------------------------
//  poll    | in  | sjds_poll_if   | four button flags, rotate and grab angles
//  cmd     | out | sjds_cmd_if    | rotate and grab step commands with valids
//
//  one command item per poll item; an accepted poll item is held in the input register,
//  then in the result register, whose valid flag drives cmd.valid
//  one poll item is taken every cycle while cmd keeps up: the input register
//  hands its item to the result register whenever that register is empty or drained
//  a stall on cmd holds the result, then the input register, then poll.ready falls
//  reset clears all run flags, latched targets and both valid flags
`default_nettype none

module servo_jog_with_detent_stops
    import sjds_pkg::*;
#(
    parameter int unsigned MAX_ANGLE = 180
) (
    input  wire         clk,
    input  wire         rst_n,
    sjds_poll_if.sink   poll,
    sjds_cmd_if.source  cmd
);

    logic       poll_valid_reg;
    poll_item_t poll_item_reg;
    logic       cmd_valid_reg;
    cmd_item_t  cmd_item_reg;
    jog_state_t state_reg;
    jog_state_t state_next;
    cmd_item_t  result;
    poll_item_t poll_item;
    logic       advance;
    logic       poll_take;

    // gather incoming payload
    always_comb
    begin
        poll_item.up_press = poll.up_press;
        poll_item.down_press = poll.down_press;
        poll_item.open_press = poll.open_press;
        poll_item.close_press = poll.close_press;
        poll_item.rotate_now = poll.rotate_now;
        poll_item.grab_now = poll.grab_now;
    end

    // pipeline handshake
    assign advance = poll_valid_reg && (!cmd_valid_reg || cmd.ready);
    assign poll.ready = !poll_valid_reg || advance;
    assign poll_take = poll.valid && poll.ready;

    // step logic
    sjds_step #(
        .MAX_ANGLE (MAX_ANGLE)
    ) u_step (
        .item       (poll_item_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result)
    );

    // control state and run state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_valid_reg <= 1'b0;
            cmd_valid_reg <= 1'b0;
            state_reg <= '0;
        end
        else
        begin
            if (poll.ready)
            begin
                poll_valid_reg <= poll.valid;
            end
            if (advance)
            begin
                cmd_valid_reg <= 1'b1;
                state_reg <= state_next;
            end
            else if (cmd.ready)
            begin
                cmd_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (poll_take)
        begin
            poll_item_reg <= poll_item;
        end
        if (advance)
        begin
            cmd_item_reg <= result;
        end
    end

    // drive result channel
    assign cmd.valid = cmd_valid_reg;
    assign cmd.rotate_cmd_valid = cmd_item_reg.rotate_cmd_valid;
    assign cmd.rotate_cmd = cmd_item_reg.rotate_cmd;
    assign cmd.grab_cmd_valid = cmd_item_reg.grab_cmd_valid;
    assign cmd.grab_cmd = cmd_item_reg.grab_cmd;

endmodule

`default_nettype wire
